FILE: hw/rtl/ttrc_pkg.sv
`timescale 1ns / 1ps

package ttrc_pkg;

  // Residues are kept modulo 2^16 - 1, so a wide value folds by adding its halves.
  localparam logic [15:0] Modulus     = 16'hFFFF;
  localparam logic [7:0]  AlphaWeight = 8'd17;
  localparam logic [7:0]  BetaWeight  = 8'd31;
  localparam logic [7:0]  FirstOffset = 8'd7;

  localparam int unsigned ProdAW = 25;  // (byte + alpha) * prev: 9 x 16 bits
  localparam int unsigned ProdBW = 24;  // beta * prev_prev: 8 x 16 bits

  typedef logic [15:0] residue_t;

  // Folds a product of up to 25 bits into 0 .. Modulus-1.
  function automatic residue_t fold_mod(input logic [ProdAW-1:0] x);
    logic [16:0] sum;
    begin
      sum = {1'b0, x[15:0]} + 17'(x[ProdAW-1:16]);
      if (sum >= {1'b0, Modulus}) begin
        sum = sum - {1'b0, Modulus};
      end
      fold_mod = sum[15:0];
    end
  endfunction

endpackage

FILE: hw/rtl/three_term_recurrence_checksum.sv
`timescale 1ns / 1ps
// Output: a message's checksum is written to the result register when its last byte leaves
// the input register; that byte is held while an earlier checksum is still waiting there.
// Throughput: one byte per cycle unless a last byte waits on a full result register;
// the only loop is the recurrence through the message-state registers and its logic.
// Reset (rst_ni low, asynchronous) empties both stages and restarts the message
// state, so the next byte accepted opens a new message.
module three_term_recurrence_checksum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] checksum
);

  import ttrc_pkg::*;

  // Input register: one byte held here until the recurrence stage takes it.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Message state.
  residue_t   prev_q, prev_d;
  residue_t   prev2_q, prev2_d;
  logic [7:0] pos_q, pos_d;
  logic       open_q, open_d;

  // Result register.
  logic       out_valid_q;
  residue_t   sum_q;

  logic advance;
  logic s_fire;
  logic m_fire;

  // The held byte moves on unless it would produce a checksum while the
  // result register is still full and not being taken.
  assign m_fire        = out_valid_q & m_axis_tready;
  assign advance       = in_valid_q & (~last_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  // Recurrence arithmetic for byte number pos_q of an open message.
  logic [7:0]        alpha, beta;
  logic [8:0]        factor_a;
  logic [ProdAW-1:0] prod_a;
  logic [ProdBW-1:0] prod_b;
  residue_t          res_a, res_b;
  logic              a_below_b;
  logic signed [17:0] diff;
  residue_t          next_val;

  always_comb begin
    alpha     = 8'(pos_q * AlphaWeight);
    beta      = 8'(pos_q * BetaWeight);
    factor_a  = {1'b0, byte_q} + {1'b0, alpha};
    prod_a    = ProdAW'(factor_a) * ProdAW'(prev_q);
    prod_b    = ProdBW'(beta) * ProdBW'(prev2_q);
    res_a     = fold_mod(prod_a);
    res_b     = fold_mod(ProdAW'(prod_b));
    a_below_b = prod_a < ProdAW'(prod_b);
    // When B exceeds A the wrapped 64-bit difference is one more than the
    // plain residue difference, since 2^64 leaves remainder one.
    diff = $signed({2'b00, res_a}) - $signed({2'b00, res_b})
         + $signed({17'd0, a_below_b});
    if (diff < 0) begin
      diff = diff + $signed({2'b00, Modulus});
    end else if (diff >= $signed({2'b00, Modulus})) begin
      diff = diff - $signed({2'b00, Modulus});
    end
    next_val = diff[15:0];
  end

  always_comb begin
    prev_d  = prev_q;
    prev2_d = prev2_q;
    pos_d   = pos_q;
    open_d  = open_q;
    if (advance) begin
      if (!open_q) begin
        prev_d  = 16'({1'b0, byte_q} + {1'b0, FirstOffset});
        prev2_d = 16'd1;
        pos_d   = 8'd1;
        open_d  = 1'b1;
      end else begin
        prev_d  = next_val;
        prev2_d = prev_q;
        pos_d   = pos_q + 8'd1;
      end
      if (last_q) begin
        // The message closes: the state returns to its reset values.
        prev_d  = '0;
        prev2_d = 16'd1;
        pos_d   = '0;
        open_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      prev_q      <= '0;
      prev2_q     <= 16'd1;
      pos_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
      pos_q   <= pos_d;
      open_q  <= open_d;
      if (advance && last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (advance && last_q) begin
      // A one-byte message reports byte + 7; otherwise the freshly computed value.
      sum_q <= open_q ? next_val : 16'({1'b0, byte_q} + {1'b0, FirstOffset});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sum_q;

endmodule
